// ===== hdl/lpht_pkg.sv =====
// Shared types and codes for the linear probe hash table.
package lpht_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4
  } status_e;

endpackage

// ===== hdl/linear_probe_hash_table_unit.sv =====
// Linear probe hash table: top level.
// Usage:
//  Requests enter on in_valid_i/in_stall_o with kind_i, key_i, value_i
//  (insert, search, delete). Each request yields exactly one result on
//  out_valid_o/out_stall_i with status_o and found_value_o.
//  A two-entry request queue decouples the input from the probe engine,
//  so requests are taken while the engine works or a result waits.
//  A request passes the queue, the take, the slot index and the slot
//  read before its home slot is checked. Search and delete read each
//  further slot before checking it, as the key store has a single
//  registered read port; insert checks only the live marks. Search and
//  delete give up after a full lap, insert after a lap of a full table.
//  A DEPTH that is not a power of two adds nibble-wise key reduction.
//  Requests are handled one at a time in arrival order; the engine takes
//  the next queued request the cycle after it issues a result.
//  Reset clears all live and tombstone marks and empties the queue.
//  A stalled result holds its value; the engine may start the next request
//  but holds its result until the output is free.
module linear_probe_hash_table_unit import lpht_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] found_value_o
);
  logic        rq_valid, rq_take;
  logic [1:0]  rq_kind;
  logic [31:0] rq_key;
  logic [VALUE_WIDTH-1:0] rq_val;
  logic [VALUE_WIDTH-1:0] value_w;

  assign value_w = VALUE_WIDTH'(value_i);

  lpht_front #(.KeyW(32), .ValW(VALUE_WIDTH), .QDepth(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .key_i,
    .value_i(value_w),
    .req_valid_o(rq_valid), .req_take_i(rq_take), .req_kind_o(rq_kind),
    .req_key_o(rq_key), .req_value_o(rq_val)
  );

  lpht_back #(.Depth(DEPTH), .ValW(VALUE_WIDTH)) u_back (
    .clk_i, .rst_ni, .req_valid_i(rq_valid), .req_take_o(rq_take),
    .req_kind_i(rq_kind), .req_key_i(rq_key), .req_value_i(rq_val),
    .out_valid_o, .out_stall_i, .status_o, .found_value_o
  );
endmodule

// ===== hdl/lpht_front.sv =====
// Front end: request queue feeding the probe engine.
module lpht_front import lpht_pkg::*; #(
  parameter int KeyW = 32,
  parameter int ValW = 32,
  parameter int QDepth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      kind_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [ValW-1:0] value_i,
  output logic            req_valid_o,
  input  logic            req_take_i,
  output logic [1:0]      req_kind_o,
  output logic [KeyW-1:0] req_key_o,
  output logic [ValW-1:0] req_value_o
);
  localparam int PW = $clog2(QDepth);
  localparam int W = 2 + KeyW + ValW;

  logic [W-1:0]  mem_q [QDepth];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;

  assign in_stall_o = (cnt_q == (PW+1)'(QDepth));
  assign push = in_valid_i && !in_stall_o;
  assign pop  = req_valid_o && req_take_i;
  assign req_valid_o = (cnt_q != '0);
  assign {req_kind_o, req_key_o, req_value_o} = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= {kind_i, key_i, value_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PW'(QDepth-1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == PW'(QDepth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QDepth)) else $error("queue overflow");
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PW+1)'(QDepth)) |-> in_stall_o) else $error("full queue not stalling");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0) else $error("pop from empty queue");
endmodule

// ===== hdl/lpht_back.sv =====
// Back end: probe sequencer over the slot stores, one request and one slot at a time.
module lpht_back import lpht_pkg::*; #(
  parameter int Depth = 16,
  parameter int ValW = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_take_o,
  input  logic [1:0]  req_kind_i,
  input  logic [31:0] req_key_i,
  input  logic [ValW-1:0] req_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] found_value_o
);
  localparam int IW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam bit DepthPow2 = ((Depth & (Depth - 1)) == 0);
  localparam logic [1:0] S_IDLE = 2'd0, S_HASH = 2'd1, S_PROBE = 2'd2, S_READ = 2'd3;

  logic [31:0]     keys_q [Depth];
  logic [ValW-1:0] vals_q [Depth];
  logic [Depth-1:0] live_q, tomb_q;

  logic [1:0]   st_q;
  logic [1:0]   kind_q;
  logic [31:0]  key_q;
  logic [ValW-1:0] val_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] n_q;
  logic [31:0]  rem_q;
  logic [2:0]   hc_q;
  logic         ov_q;
  logic [2:0]   status_q;
  logic [31:0]  fv_q;
  logic [ValW-1:0] rd_q;
  logic [31:0]  rdk_q;

  logic out_free;
  assign out_free   = !ov_q || !out_stall_i;
  assign req_take_o = (st_q == S_IDLE) && req_valid_i;
  assign out_valid_o = ov_q;
  assign status_o = status_q;
  assign found_value_o = fv_q;

  logic [IW-1:0] idx_nx;
  assign idx_nx = (idx_q == IW'(Depth-1)) ? '0 : idx_q + 1'b1;
  logic [31:0] fv_ext;
  always_comb begin
    fv_ext = '0;
    for (int b = 0; b < ValW && b < 32; b++) fv_ext[b] = rd_q[b];
  end

  // One key nibble per cycle, MSB first: r = (r*16 + nibble) mod Depth,
  // reduced by four compare-and-subtract steps.
  logic [IW+3:0] fold;
  always_comb begin
    fold = {idx_q, rem_q[31:28]};
    for (int k = 3; k >= 0; k--) begin
      if (fold >= ((IW+4)'(Depth) << k)) fold = fold - ((IW+4)'(Depth) << k);
    end
  end

  logic slot_empty, key_hit, finish;
  assign slot_empty = !live_q[idx_q] && !tomb_q[idx_q];
  assign key_hit    = live_q[idx_q] && (rdk_q == key_q);
  assign finish = (st_q == S_PROBE) && out_free &&
                  ((n_q == CW'(Depth)) ||
                   ((kind_q == KIND_INSERT) ? !live_q[idx_q]
                                            : (kind_q == KIND_NONE || slot_empty || key_hit)));

  // Store write on insert; a delete only sets the tombstone mark in the probe state.
  logic wr_en;
  assign wr_en = (st_q == S_PROBE) && (kind_q == KIND_INSERT) && !live_q[idx_q]
                 && (n_q != CW'(Depth)) && out_free;
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      keys_q[idx_q] <= key_q;
      vals_q[idx_q] <= val_q;
    end
    rd_q  <= vals_q[idx_q];
    rdk_q <= keys_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ov_q <= 1'b0; live_q <= '0; tomb_q <= '0;
      idx_q <= '0; n_q <= '0;
    end else begin
      ov_q <= finish || (ov_q && out_stall_i);
      unique case (st_q)
        S_IDLE: if (req_take_o) begin
          kind_q <= req_kind_i; key_q <= req_key_i; val_q <= req_value_i;
          rem_q <= req_key_i; n_q <= '0; idx_q <= '0; hc_q <= '0;
          st_q <= S_HASH;
        end
        // Power-of-two depth is a mask; otherwise reduced one nibble at a time over all eight key nibbles.
        S_HASH: begin
          if (DepthPow2) begin
            idx_q <= rem_q[IW-1:0];
            st_q <= S_READ;
          end else begin
            idx_q <= fold[IW-1:0];
            rem_q <= {rem_q[27:0], 4'h0};
            hc_q <= hc_q + 1'b1;
            if (hc_q == 3'd7) st_q <= S_READ;
          end
        end
        S_READ: st_q <= S_PROBE; // registered key/value read of current slot
        S_PROBE: if (out_free) begin
          if (n_q == CW'(Depth)) begin
            status_q <= (kind_q == KIND_INSERT) ? ST_FULL : ST_NOT_FOUND;
            fv_q <= '0; st_q <= S_IDLE;
          end else if (kind_q == KIND_INSERT) begin
            if (!live_q[idx_q]) begin
              live_q[idx_q] <= 1'b1; tomb_q[idx_q] <= 1'b0;
              status_q <= ST_INSERTED; fv_q <= '0; st_q <= S_IDLE;
            end else begin
              idx_q <= idx_nx; n_q <= n_q + 1'b1;
            end
          end else if (kind_q == KIND_NONE || slot_empty) begin
            status_q <= ST_NOT_FOUND; fv_q <= '0; st_q <= S_IDLE;
          end else if (key_hit) begin
            if (kind_q == KIND_SEARCH) begin
              status_q <= ST_FOUND; fv_q <= fv_ext;
            end else begin
              live_q[idx_q] <= 1'b0; tomb_q[idx_q] <= 1'b1;
              status_q <= ST_DELETED; fv_q <= '0;
            end
            st_q <= S_IDLE;
          end else begin
            idx_q <= idx_nx; n_q <= n_q + 1'b1; st_q <= S_READ;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  a_live_tomb_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q & tomb_q) == '0) else $error("slot both live and tombstoned");
  a_lap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(Depth)) else $error("probe ran past one lap");
  a_found_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && status_q != ST_FOUND) |-> fv_q == '0) else $error("stray found value");
endmodule
